>>> hw/rtl/omni_chassis_velocity_mixer_assert.svh
// Assertion macros shared by the velocity mixer RTL.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef OMNI_CHASSIS_VELOCITY_MIXER_ASSERT_SVH
`define OMNI_CHASSIS_VELOCITY_MIXER_ASSERT_SVH

// Same-cycle implication, off during reset
`define OCVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define OCVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ocvm_pkg.sv
// Package for the omni chassis velocity mixer: widths, constants, command types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ocvm_pkg;

  localparam int FRACTION_BITS = 15;
  localparam int TRIG_BITS     = 15;
  localparam int CORDIC_STEPS  = 14;
  localparam int DIV_STEPS     = 14;
  localparam int STEP_W        = 4;
  localparam int WIDE_W        = 36;
  localparam int NUM_W         = 50;

  localparam logic [16:0] ONE_Q = 17'(1) << FRACTION_BITS;
  localparam logic [WIDE_W-1:0] DIV_FLOOR = WIDE_W'(1) << (FRACTION_BITS + TRIG_BITS);
  localparam logic signed [17:0] CORDIC_GAIN = 18'sd19898;

  // register indexes
  localparam logic [2:0] REG_TRANS_CAP   = 3'd0;
  localparam logic [2:0] REG_SPEED_BOOST = 3'd1;
  localparam logic [2:0] REG_YAW_CAP     = 3'd2;
  localparam logic [2:0] REG_ACCEL_STEP  = 3'd3;
  localparam logic [2:0] REG_SPIN_STEP   = 3'd4;
  localparam logic [2:0] REG_MAX_RPM     = 3'd5;
  localparam logic [2:0] REG_MIX_SIGNS   = 3'd6;

  typedef struct packed {
    logic [15:0] trans_cap;
    logic [15:0] speed_boost;
    logic [15:0] yaw_cap;
    logic [15:0] accel_step;
    logic [15:0] spin_step;
    logic [13:0] max_rpm;
    logic [11:0] mix_signs;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RAMP, OP_ZERO, OP_CORDIC, OP_ROT,
    OP_MIX, OP_MAX, OP_SCALE, OP_DIV, OP_STORE, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic [1:0]        wheel;
  } cmd_t;

  typedef struct packed {
    logic enabled;
  } status_t;

  // arctangent of 2^-i as a binary angle (32768 = pi)
  function automatic logic signed [16:0] atan_bin(input logic [STEP_W-1:0] i);
    logic signed [16:0] a;
    unique case (i)
      4'd0:    a = 17'sd8192;
      4'd1:    a = 17'sd4836;
      4'd2:    a = 17'sd2555;
      4'd3:    a = 17'sd1297;
      4'd4:    a = 17'sd651;
      4'd5:    a = 17'sd326;
      4'd6:    a = 17'sd163;
      4'd7:    a = 17'sd81;
      4'd8:    a = 17'sd41;
      4'd9:    a = 17'sd20;
      4'd10:   a = 17'sd10;
      4'd11:   a = 17'sd5;
      4'd12:   a = 17'sd3;
      4'd13:   a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ocvm_datapath.sv
// Datapath of the velocity mixer: ramps, CORDIC, rotation, wheel mix, divider.
// Depends on ocvm_pkg; driven by commands from ocvm_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ocvm_datapath
  import ocvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire cfg_t        cfg,
  input  wire logic [63:0] in_data,
  input  wire logic [1:0]  in_user,
  output logic [59:0]      out_data
);

  function automatic logic signed [16:0] clamp_sym(input logic signed [15:0] v,
                                                   input logic [16:0] lim);
    logic signed [17:0] vv;
    logic signed [17:0] ll;
    vv = 18'(v);
    ll = $signed({1'b0, lim});
    if (vv > ll) return 17'(ll);
    else if (vv < -ll) return 17'(-ll);
    else return 17'(vv);
  endfunction

  function automatic logic signed [16:0] ramp_next(input logic signed [16:0] tgt,
                                                   input logic signed [16:0] cur,
                                                   input logic [15:0] stp);
    logic signed [17:0] gap;
    logic [17:0] mag;
    logic signed [17:0] s;
    gap = 18'(tgt) - 18'(cur);
    mag = gap[17] ? 18'(-gap) : 18'(gap);
    s = $signed({2'b00, stp});
    if (tgt == 17'sd0) return 17'sd0;
    else if (mag < {2'b00, stp}) return tgt;
    else if (gap > 18'sd0) return 17'(18'(cur) + s);
    else return 17'(18'(cur) - s);
  endfunction

  function automatic logic [WIDE_W-1:0] mag_w(input logic signed [WIDE_W-1:0] v);
    return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

  // latched input word
  logic               en, spin;
  logic signed [15:0] cmd_f, cmd_h, cmd_y, angle;
  // ramp state
  logic signed [16:0] ramp_f, ramp_h, ramp_y;
  // CORDIC
  logic signed [17:0] cx, cy;
  logic signed [16:0] cz;
  logic               flip;
  // rotation and mix
  logic signed [WIDE_W-1:0] rot_f, rot_h;
  logic signed [WIDE_W-1:0] wheel [4];
  logic [WIDE_W-1:0]        divisor;
  // divider
  logic [NUM_W-1:0]   num;
  logic [DIV_STEPS-1:0] quot;
  logic               neg;
  logic signed [14:0] res [4];
  logic signed [14:0] res_out [4];

  logic [16:0]        lim;
  logic signed [16:0] tgt_f, tgt_h, tgt_y;
  logic signed [15:0] phi;
  logic signed [16:0] phi_fold;
  logic               phi_flip;
  logic signed [17:0] dx, dy, nx, ny;
  logic signed [16:0] at;
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] prod;
  logic signed [WIDE_W-1:0] ry;
  logic signed [WIDE_W-1:0] mix [4];
  logic [WIDE_W-1:0]  mx01, mx23, mx;
  logic [3:0]         qidx;
  logic [NUM_W-1:0]   dshift;

  assign status.enabled = en;

  // command limits and clamped targets
  always_comb begin
    lim = ((cfg.trans_cap > ONE_Q[15:0]) || (cfg.trans_cap == ONE_Q[15:0]))
          ? ONE_Q : {1'b0, cfg.trans_cap};
    if (!spin) lim = 17'(lim + {1'b0, cfg.speed_boost});
    tgt_f = clamp_sym(cmd_f, lim);
    tgt_h = clamp_sym(cmd_h, lim);
    tgt_y = clamp_sym(cmd_y, {1'b0, cfg.yaw_cap});
  end

  // angle fold into -pi/2..pi/2
  always_comb begin
    phi = 16'(16'sd0 - angle);
    phi_flip = 1'b0;
    phi_fold = 17'(phi);
    if (phi > 16'sd16384) begin
      phi_fold = 17'(phi) - 17'sd32768;
      phi_flip = 1'b1;
    end else if (phi < -16'sd16384) begin
      phi_fold = 17'(phi) + 17'sd32768;
      phi_flip = 1'b1;
    end
  end

  // one CORDIC micro-rotation
  always_comb begin
    dx = cy >>> cmd.step;
    dy = cx >>> cmd.step;
    at = atan_bin(cmd.step);
    if (!cz[16]) begin
      nx = cx - dx;
      ny = cy + dy;
    end else begin
      nx = cx + dx;
      ny = cy - dy;
    end
  end

  // shared rotation multiplier
  always_comb begin
    mul_a = (cmd.step[1:0] == 2'd0 || cmd.step[1:0] == 2'd3) ? ramp_f : ramp_h;
    mul_b = (cmd.step[1:0] == 2'd0 || cmd.step[1:0] == 2'd2) ? cx : cy;
    prod  = 35'(mul_a) * 35'(mul_b);
  end

  // wheel sums and largest magnitude
  always_comb begin
    ry = WIDE_W'(ramp_y) <<< TRIG_BITS;
    for (int k = 0; k < 4; k++) begin
      mix[k] = (cfg.mix_signs[3*k]   ? -rot_f : rot_f)
             + (cfg.mix_signs[3*k+1] ? -rot_h : rot_h)
             + (cfg.mix_signs[3*k+2] ? -ry    : ry);
    end
    mx01 = (mag_w(wheel[0]) > mag_w(wheel[1])) ? mag_w(wheel[0]) : mag_w(wheel[1]);
    mx23 = (mag_w(wheel[2]) > mag_w(wheel[3])) ? mag_w(wheel[2]) : mag_w(wheel[3]);
    mx   = (mx01 > mx23) ? mx01 : mx23;
  end

  // restoring divide, one quotient bit a step
  always_comb begin
    qidx   = 4'(DIV_STEPS - 1) - cmd.step;
    dshift = NUM_W'(divisor) << qidx;
  end

  // ramp state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_f <= '0;
      ramp_h <= '0;
      ramp_y <= '0;
    end else if (cmd.op == OP_RAMP) begin
      ramp_f <= ramp_next(tgt_f, ramp_f, cfg.accel_step);
      ramp_h <= ramp_next(tgt_h, ramp_h, cfg.accel_step);
      ramp_y <= ramp_next(tgt_y, ramp_y, cfg.spin_step);
    end
  end

  // enabled flag is control state
  always_ff @(posedge clk) begin
    if (rst) begin
      en <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      en <= in_user[0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        spin  <= in_user[1];
        cmd_f <= in_data[15:0];
        cmd_h <= in_data[31:16];
        cmd_y <= in_data[47:32];
        angle <= in_data[63:48];
      end
      OP_RAMP: begin
        cx   <= CORDIC_GAIN;
        cy   <= '0;
        cz   <= phi_fold;
        flip <= phi_flip;
      end
      OP_CORDIC: begin
        if (cmd.step == STEP_W'(CORDIC_STEPS - 1) && flip) begin
          cx <= -nx;
          cy <= -ny;
        end else begin
          cx <= nx;
          cy <= ny;
        end
        cz <= cz[16] ? cz + at : cz - at;
      end
      OP_ROT: begin
        unique case (cmd.step[1:0])
          2'd0: rot_f <= WIDE_W'(prod);
          2'd1: rot_f <= rot_f - WIDE_W'(prod);
          2'd2: rot_h <= -WIDE_W'(prod);
          2'd3: rot_h <= rot_h - WIDE_W'(prod);
          default: ;
        endcase
      end
      OP_MIX: begin
        for (int k = 0; k < 4; k++) wheel[k] <= mix[k];
      end
      OP_MAX: divisor <= (mx > DIV_FLOOR) ? mx : DIV_FLOOR;
      OP_SCALE: begin
        num  <= NUM_W'(mag_w(wheel[cmd.wheel])) * NUM_W'(cfg.max_rpm);
        quot <= '0;
        neg  <= wheel[cmd.wheel][WIDE_W-1];
      end
      OP_DIV: begin
        if (num >= dshift) begin
          num        <= num - dshift;
          quot[qidx] <= 1'b1;
        end
      end
      OP_STORE: res[cmd.wheel] <= neg ? -15'({1'b0, quot}) : 15'({1'b0, quot});
      OP_ZERO: begin
        for (int k = 0; k < 4; k++) res[k] <= '0;
      end
      OP_PUBLISH: begin
        for (int k = 0; k < 4; k++) res_out[k] <= res[k];
      end
      default: ;
    endcase
  end

  assign out_data = {res_out[3], res_out[2], res_out[1], res_out[0]};

endmodule
`default_nettype wire

>>> hw/rtl/ocvm_ctrl.sv
// Sequencer for the velocity mixer: steps the datapath and owns the output valid.
// Depends on ocvm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "omni_chassis_velocity_mixer_assert.svh"
module ocvm_ctrl
  import ocvm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cmd_t         cmd,
  input  wire status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CORDIC, S_ROT, S_MIX, S_MAX, S_SCALE, S_DIV, S_STORE, S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [1:0]        wheel;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd.step  = step;
    cmd.wheel = wheel;
    unique case (state)
      S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_CHECK:  cmd.op = status.enabled ? OP_RAMP : OP_ZERO;
      S_CORDIC: cmd.op = OP_CORDIC;
      S_ROT:    cmd.op = OP_ROT;
      S_MIX:    cmd.op = OP_MIX;
      S_MAX:    cmd.op = OP_MAX;
      S_SCALE:  cmd.op = OP_SCALE;
      S_DIV:    cmd.op = OP_DIV;
      S_STORE:  cmd.op = OP_STORE;
      S_DONE:   cmd.op = slot_free ? OP_PUBLISH : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      wheel     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new word takes the slot; otherwise a taken word empties it
      if (state == S_DONE && slot_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          step  <= '0;
          state <= status.enabled ? S_CORDIC : S_DONE;
        end
        S_CORDIC: begin
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            step  <= '0;
            state <= S_ROT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROT: begin
          if (step == STEP_W'(3)) begin
            step  <= '0;
            state <= S_MIX;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MIX: state <= S_MAX;
        S_MAX: begin
          wheel <= '0;
          state <= S_SCALE;
        end
        S_SCALE: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_STORE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_STORE: begin
          if (wheel == 2'd3) begin
            state <= S_DONE;
          end else begin
            wheel <= wheel + 1'b1;
            state <= S_SCALE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OCVM_ASSERT_NXT(a_accept_check, in_valid && in_ready, state == S_CHECK, "accept not followed by check")
  `OCVM_ASSERT_IMP(a_valid_from_done, $rose(out_valid), $past(state) == S_DONE, "word published outside done")
  `OCVM_ASSERT_NXT(a_done_publish, state == S_DONE && slot_free, out_valid && state == S_IDLE, "free slot not filled")
  `OCVM_ASSERT_IMP(a_div_bound, state == S_DIV, step < STEP_W'(DIV_STEPS), "divider step out of range")

endmodule
`default_nettype wire

>>> hw/rtl/omni_chassis_velocity_mixer.sv
// Omni chassis velocity mixer: config registers, sequencer and datapath.
// Depends on ocvm_pkg, ocvm_ctrl and ocvm_datapath.
// Enabled word: m_tvalid rises once the datapath has run 14 CORDIC steps, 4 shared
//   multiplies and a 14-step divide per wheel; no new word is taken before that.
// Disabled word: S_CHECK zeroes the results and S_DONE publishes them.
// Synchronous reset clears ramps, registers to defaults and the handshake state.
`timescale 1ns / 1ps
`default_nettype none
module omni_chassis_velocity_mixer
  import ocvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // cmd_forward, cmd_sideways, cmd_yaw, turret_angle
  input  wire logic [1:0]  s_tuser,   // enabled, spin_mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // front_right, front_left, back_left, back_right, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t        cfg;
  cmd_t        cmd;
  status_t     status;
  logic [59:0] out_data;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0000, out_data};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trans_cap   <= 16'd32768;
      cfg.speed_boost <= 16'd0;
      cfg.yaw_cap     <= 16'd32768;
      cfg.accel_step  <= 16'd328;
      cfg.spin_step   <= 16'd328;
      cfg.max_rpm     <= 14'd9000;
      cfg.mix_signs   <= 12'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRANS_CAP:   cfg.trans_cap   <= cfg_data;
        REG_SPEED_BOOST: cfg.speed_boost <= cfg_data;
        REG_YAW_CAP:     cfg.yaw_cap     <= cfg_data;
        REG_ACCEL_STEP:  cfg.accel_step  <= cfg_data;
        REG_SPIN_STEP:   cfg.spin_step   <= cfg_data;
        REG_MAX_RPM:     cfg.max_rpm     <= cfg_data[13:0];
        REG_MIX_SIGNS:   cfg.mix_signs   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ocvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ocvm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
